>>> rtl/otfq_pkg.sv
// shared widths and types for the over temperature fault qualifier
`default_nettype none

package otfq_pkg;

    localparam int SENSOR_W    = 10;
    localparam int TICK_W      = 16;
    localparam int NUM_LANES   = 3;
    localparam int PHASE_W     = 3;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SET_LEVEL   = 2'd0,
        REG_SET_TICKS   = 2'd1,
        REG_CLEAR_LEVEL = 2'd2,
        REG_CLEAR_TICKS = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] set_level;
        logic [TICK_W-1:0]   set_ticks;
        logic [SENSOR_W-1:0] clear_level;
        logic [TICK_W-1:0]   clear_ticks;
    } cfg_t;

    typedef struct packed {
        logic hot;
        logic cool;
    } lane_flags_t;

    typedef struct packed {
        logic charger_active;
        logic charger_off;
        logic device_standby;
        logic device_starting;
    } status_flags_t;

endpackage

`default_nettype wire

>>> rtl/otfq_lane.sv
// one sensor lane: compares a reading against the set and clear levels
`default_nettype none

module otfq_lane (
    input  wire logic [otfq_pkg::SENSOR_W-1:0] sensor,
    input  wire logic [otfq_pkg::SENSOR_W-1:0] set_level,
    input  wire logic [otfq_pkg::SENSOR_W-1:0] clear_level,
    output otfq_pkg::lane_flags_t               flags
);
    import otfq_pkg::*;

    // lower reading means hotter
    assign flags.hot  = (sensor <= set_level);
    assign flags.cool = (sensor >= clear_level);

endmodule

`default_nettype wire

>>> rtl/otfq_fsm.sv
// lane merge, phase state machine, tick timer and result register
`default_nettype none

module otfq_fsm (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   accept,
    input  wire otfq_pkg::lane_flags_t [otfq_pkg::NUM_LANES-1:0] lane_flags,
    input  wire otfq_pkg::status_flags_t                status,
    input  wire otfq_pkg::cfg_t                         cfg,
    input  wire logic                                   m_tready,
    output logic                                        m_tvalid,
    output logic                                        over_temp_fault,
    output logic [otfq_pkg::PHASE_W-1:0]                check_phase
);
    import otfq_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_INIT      = 3'd0,
        PH_NORMAL    = 3'd1,
        PH_ON_CHECK  = 3'd2,
        PH_FAULT     = 3'd3,
        PH_OFF_CHECK = 3'd4
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   count_reg, count_next, count_inc;
    logic                running_reg, running_next;
    logic                fault_reg, fault_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                any_hot, all_cool;

    // merge of lane results
    always_comb begin
        any_hot  = 1'b0;
        all_cool = 1'b1;
        for (int i = 0; i < NUM_LANES; i++) begin
            any_hot  = any_hot | lane_flags[i].hot;
            all_cool = all_cool & lane_flags[i].cool;
        end
    end

    always_comb begin
        count_inc = count_reg;
        if (running_reg && (count_reg != {TICK_W{1'b1}})) begin
            count_inc = count_reg + 1'b1;
        end

        phase_next   = phase_reg;
        count_next   = count_inc;
        running_next = running_reg;
        fault_next   = fault_reg;

        unique case (phase_reg)
            PH_INIT: begin
                fault_next   = 1'b0;
                running_next = 1'b0;
                count_next   = '0;
                phase_next   = PH_NORMAL;
            end
            PH_NORMAL: begin
                if (status.charger_active && !status.device_standby &&
                    !status.device_starting && any_hot) begin
                    running_next = 1'b1;
                    count_next   = '0;
                    phase_next   = PH_ON_CHECK;
                end
            end
            PH_ON_CHECK: begin
                if (status.charger_off || status.device_standby || !any_hot) begin
                    running_next = 1'b0;
                    count_next   = '0;
                    phase_next   = PH_NORMAL;
                end else if (count_inc >= cfg.set_ticks) begin
                    running_next = 1'b0;
                    count_next   = '0;
                    fault_next   = 1'b1;
                    phase_next   = PH_FAULT;
                end
            end
            PH_FAULT: begin
                if (status.charger_off) begin
                    fault_next = 1'b0;
                    phase_next = PH_NORMAL;
                end else if (all_cool) begin
                    running_next = 1'b1;
                    count_next   = '0;
                    phase_next   = PH_OFF_CHECK;
                end
            end
            PH_OFF_CHECK: begin
                if (status.charger_off || (count_inc >= cfg.clear_ticks)) begin
                    running_next = 1'b0;
                    count_next   = '0;
                    fault_next   = 1'b0;
                    phase_next   = PH_NORMAL;
                end else if (!all_cool) begin
                    running_next = 1'b0;
                    count_next   = '0;
                    fault_next   = 1'b1;
                    phase_next   = PH_FAULT;
                end
            end
            default: begin
                phase_next = PH_INIT;
            end
        endcase

        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_INIT;
            count_reg    <= '0;
            running_reg  <= 1'b0;
            fault_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                running_reg <= running_next;
                fault_reg   <= fault_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // state only moves on an accepted request, so it doubles as the result
    assign m_tvalid        = m_tvalid_reg;
    assign over_temp_fault = fault_reg;
    assign check_phase     = phase_reg;

endmodule

`default_nettype wire

>>> rtl/over_temperature_fault_qualifier.sv
// top level of the over temperature fault qualifier
//
// one request per tick on the s_ channel carries three ntc readings and
// the charger and device status flags; each request yields exactly one
// result on the m_ channel with the fault flag and the check phase as
// they stand after that tick.
// three compare lanes work on the readings side by side and a merge
// feeds the phase machine and its 16-bit saturating tick timer.
// latency: the result is valid in the cycle after the request is taken.
// throughput: one request per cycle; s_tready stays high while the
// result register is empty or being drained in the same cycle.
// when the receiver stalls, the result holds and s_tready stays low,
// so requests wait until m_tready returns. reset (aresetn low at a clock
// edge) puts the machine in its init phase, stops the timer, clears the
// fault and all four registers. registers are written through cfg_we /
// cfg_addr / cfg_wdata; users write them only while idle (unchecked).
`default_nettype none

module over_temperature_fault_qualifier (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // sensor_a, sensor_b, sensor_c, charger_active, charger_off,
    // device_standby, device_starting, zero pad
    input  wire logic [otfq_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // over_temp_fault, check_phase, zero pad
    output logic [otfq_pkg::M_TDATA_W-1:0]           m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [otfq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [otfq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import otfq_pkg::*;

    cfg_t                               cfg_reg;
    logic [SENSOR_W-1:0]                sensors [NUM_LANES];
    lane_flags_t [NUM_LANES-1:0]        lane_flags;
    status_flags_t                      status;
    logic                               accept;
    logic                               fault;
    logic [PHASE_W-1:0]                 phase;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_SET_LEVEL:   cfg_reg.set_level   <= cfg_wdata[SENSOR_W-1:0];
                REG_SET_TICKS:   cfg_reg.set_ticks   <= cfg_wdata[TICK_W-1:0];
                REG_CLEAR_LEVEL: cfg_reg.clear_level <= cfg_wdata[SENSOR_W-1:0];
                REG_CLEAR_TICKS: cfg_reg.clear_ticks <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            sensors[i] = s_tdata[i*SENSOR_W +: SENSOR_W];
        end
    end

    assign status.charger_active  = s_tdata[NUM_LANES*SENSOR_W];
    assign status.charger_off     = s_tdata[NUM_LANES*SENSOR_W + 1];
    assign status.device_standby  = s_tdata[NUM_LANES*SENSOR_W + 2];
    assign status.device_starting = s_tdata[NUM_LANES*SENSOR_W + 3];

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        otfq_lane u_lane (
            .sensor      (sensors[g]),
            .set_level   (cfg_reg.set_level),
            .clear_level (cfg_reg.clear_level),
            .flags       (lane_flags[g])
        );
    end

    otfq_fsm u_fsm (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .lane_flags      (lane_flags),
        .status          (status),
        .cfg             (cfg_reg),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .over_temp_fault (fault),
        .check_phase     (phase)
    );

    assign m_tdata = {{(M_TDATA_W-PHASE_W-1){1'b0}}, phase, fault};

endmodule

`default_nettype wire

>>> test/testbench.sv
// testbench for the over temperature fault qualifier: directed and random requests against a predictor
`timescale 1ns / 1ps

module testbench;
    import otfq_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_MAX    = 14;

    typedef enum logic [PHASE_W-1:0] {
        PH_INIT      = 3'd0,
        PH_NORMAL    = 3'd1,
        PH_ON_CHECK  = 3'd2,
        PH_FAULT     = 3'd3,
        PH_OFF_CHECK = 3'd4
    } check_phase_t;

    typedef enum int {
        BURST_HOT,
        BURST_COOL,
        BURST_NOISE
    } burst_kind_t;

    typedef struct {
        logic [SENSOR_W-1:0] sensor_a;
        logic [SENSOR_W-1:0] sensor_b;
        logic [SENSOR_W-1:0] sensor_c;
        logic                charger_active;
        logic                charger_off;
        logic                device_standby;
        logic                device_starting;
    } reading_t;

    typedef struct {
        logic         fault;
        check_phase_t phase;
    } verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    cfg_t          regs_now = '0;
    check_phase_t  qual_phase = PH_INIT;
    logic [TICK_W-1:0] qual_ticks = '0;
    logic          qual_timing = 1'b0;
    logic          qual_fault = 1'b0;

    verdict_t verdict_q[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       idle_max = IDLE_MAX;

    over_temperature_fault_qualifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic verdict_t advance_qualifier(input reading_t r);
        logic     any_hot;
        logic     all_cool;
        verdict_t v;
        any_hot = (r.sensor_a <= regs_now.set_level) || (r.sensor_b <= regs_now.set_level) ||
                  (r.sensor_c <= regs_now.set_level);
        all_cool = (r.sensor_a >= regs_now.clear_level) &&
                   (r.sensor_b >= regs_now.clear_level) &&
                   (r.sensor_c >= regs_now.clear_level);
        if (qual_timing && qual_ticks != 16'hFFFF)
            qual_ticks = qual_ticks + 1'b1;
        case (qual_phase)
            PH_INIT: begin
                qual_fault = 1'b0;
                qual_timing = 1'b0;
                qual_ticks = '0;
                qual_phase = PH_NORMAL;
            end
            PH_NORMAL: begin
                if (r.charger_active && !r.device_standby && !r.device_starting && any_hot) begin
                    qual_timing = 1'b1;
                    qual_ticks = '0;
                    qual_phase = PH_ON_CHECK;
                end
            end
            PH_ON_CHECK: begin
                if (r.charger_off || r.device_standby || !any_hot) begin
                    qual_timing = 1'b0;
                    qual_ticks = '0;
                    qual_phase = PH_NORMAL;
                end else if (qual_ticks >= regs_now.set_ticks) begin
                    qual_timing = 1'b0;
                    qual_ticks = '0;
                    qual_fault = 1'b1;
                    qual_phase = PH_FAULT;
                end
            end
            PH_FAULT: begin
                if (r.charger_off) begin
                    qual_fault = 1'b0;
                    qual_phase = PH_NORMAL;
                end else if (all_cool) begin
                    qual_timing = 1'b1;
                    qual_ticks = '0;
                    qual_phase = PH_OFF_CHECK;
                end
            end
            PH_OFF_CHECK: begin
                if (r.charger_off || qual_ticks >= regs_now.clear_ticks) begin
                    qual_timing = 1'b0;
                    qual_ticks = '0;
                    qual_fault = 1'b0;
                    qual_phase = PH_NORMAL;
                end else if (!all_cool) begin
                    qual_timing = 1'b0;
                    qual_ticks = '0;
                    qual_fault = 1'b1;
                    qual_phase = PH_FAULT;
                end
            end
            default: begin
                qual_phase = PH_INIT;
            end
        endcase
        v.fault = qual_fault;
        v.phase = qual_phase;
        return v;
    endfunction

    function automatic int draw_wait();
        return (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    endfunction

    function automatic reading_t make_reading(input int a, input int b, input int c,
                                              input bit act, input bit off,
                                              input bit stb, input bit start);
        reading_t r;
        r.sensor_a = SENSOR_W'(a);
        r.sensor_b = SENSOR_W'(b);
        r.sensor_c = SENSOR_W'(c);
        r.charger_active = act;
        r.charger_off = off;
        r.device_standby = stb;
        r.device_starting = start;
        return r;
    endfunction

    task automatic send_reading(input reading_t r);
        int gap;
        gap = draw_wait();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {6'b0, r.device_starting, r.device_standby, r.charger_off,
                   r.charger_active, r.sensor_c, r.sensor_b, r.sensor_a};
        s_tvalid = 1'b1;
        forever begin
            @(posedge aclk);
            if (s_tready === 1'b1)
                break;
        end
        verdict_q.push_back(advance_qualifier(r));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (verdict_q.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_SET_LEVEL:   regs_now.set_level = value[SENSOR_W-1:0];
            REG_SET_TICKS:   regs_now.set_ticks = value;
            REG_CLEAR_LEVEL: regs_now.clear_level = value[SENSOR_W-1:0];
            REG_CLEAR_TICKS: regs_now.clear_ticks = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input int set_level, input int set_ticks,
                             input int clear_level, input int clear_ticks);
        write_reg(REG_SET_LEVEL, {6'($urandom), 10'(set_level)});
        write_reg(REG_SET_TICKS, 16'(set_ticks));
        write_reg(REG_CLEAR_LEVEL, {6'($urandom), 10'(clear_level)});
        write_reg(REG_CLEAR_TICKS, 16'(clear_ticks));
    endtask

    // receiver side: random stall before each result
    initial begin
        int stall;
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
                m_tready = 1'b1;
            end
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin : check_result
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result with no request pending", m_tdata, 0);
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.fault)
                    report_mismatch("over_temp_fault", m_tdata[0], want.fault);
                if (m_tdata[3:1] !== want.phase)
                    report_mismatch("check_phase", m_tdata[3:1], want.phase);
            end
        end
    end

    // all registers at zero: a reading of zero is hot and every reading is cool
    task automatic test_reset_values();
        send_reading(make_reading(0, 1023, 1023, 1, 0, 0, 0));
        send_reading(make_reading(0, 1023, 1023, 1, 0, 0, 0));
        send_reading(make_reading(0, 1023, 1023, 1, 0, 0, 0));
        send_reading(make_reading(0, 1023, 1023, 1, 0, 0, 0));
        send_reading(make_reading(5, 5, 5, 1, 0, 0, 0));
        send_reading(make_reading(1, 1, 1, 1, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_directed();
        write_all(300, 3, 700, 4);
        send_reading(make_reading(0, 1023, 1023, 1, 0, 0, 1));
        send_reading(make_reading(1023, 0, 1023, 1, 0, 1, 0));
        send_reading(make_reading(1023, 1023, 0, 0, 0, 0, 0));
        send_reading(make_reading(0, 1023, 1023, 1, 0, 0, 0));
        send_reading(make_reading(1023, 1023, 1023, 1, 0, 0, 0));
        send_reading(make_reading(1023, 300, 1023, 1, 0, 0, 0));
        send_reading(make_reading(1023, 300, 1023, 1, 0, 1, 0));
        send_reading(make_reading(1023, 1023, 300, 1, 0, 0, 0));
        // charger active and off together
        send_reading(make_reading(1023, 1023, 300, 1, 1, 0, 0));
        send_reading(make_reading(301, 301, 0, 1, 0, 0, 0));
        repeat (3) send_reading(make_reading(0, 0, 0, 1, 0, 0, 0));
        send_reading(make_reading(700, 700, 700, 0, 0, 0, 0));
        send_reading(make_reading(700, 699, 1023, 0, 0, 0, 0));
        repeat (5) send_reading(make_reading(1023, 1023, 1023, 0, 0, 0, 0));
        repeat (4) send_reading(make_reading(0, 0, 0, 1, 0, 0, 0));
        send_reading(make_reading(0, 0, 0, 0, 1, 0, 0));
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_all(1023, 0, 0, 16'hFFFF);
        repeat (5) send_reading(make_reading(1023, 1023, 1023, 1, 0, 0, 0));
        send_reading(make_reading(1023, 1023, 1023, 1, 1, 0, 0));
        wait_drained();
        write_all(0, 1, 1023, 0);
        send_reading(make_reading(0, 5, 5, 1, 0, 0, 0));
        send_reading(make_reading(0, 5, 5, 1, 0, 0, 0));
        send_reading(make_reading(1023, 1023, 1022, 1, 0, 0, 0));
        send_reading(make_reading(1023, 1023, 1023, 1, 0, 0, 0));
        send_reading(make_reading(1023, 1023, 1023, 1, 0, 0, 0));
        send_reading(make_reading(1, 1, 1, 1, 0, 0, 0));
        wait_drained();
    endtask

    // tick timer counts back to back requests up to the set time
    task automatic test_timer_top();
        write_all(1023, 40, 1023, 0);
        idle_max = 0;
        repeat (42) send_reading(make_reading(512, 512, 512, 1, 0, 0, 0));
        send_reading(make_reading(1023, 1023, 1023, 1, 0, 0, 0));
        send_reading(make_reading(1023, 1023, 1023, 1, 0, 0, 0));
        wait_drained();
        idle_max = IDLE_MAX;
    endtask

    function automatic int pick_level();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1023;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic int pick_ticks();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 16'hFFFF;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic reading_t random_reading(input burst_kind_t kind);
        reading_t r;
        int       lane;
        int       hot_val;
        r = make_reading($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        case (kind)
            BURST_HOT: begin
                lane = $urandom_range(0, 2);
                hot_val = $urandom_range(0, regs_now.set_level);
                if (lane == 0) r.sensor_a = SENSOR_W'(hot_val);
                else if (lane == 1) r.sensor_b = SENSOR_W'(hot_val);
                else r.sensor_c = SENSOR_W'(hot_val);
                r.charger_active = ($urandom_range(0, 15) != 0);
                r.charger_off = ($urandom_range(0, 15) == 0);
                r.device_standby = ($urandom_range(0, 15) == 0);
                r.device_starting = ($urandom_range(0, 15) == 0);
            end
            BURST_COOL: begin
                r.sensor_a = SENSOR_W'($urandom_range(regs_now.clear_level, 1023));
                r.sensor_b = SENSOR_W'($urandom_range(regs_now.clear_level, 1023));
                r.sensor_c = SENSOR_W'($urandom_range(regs_now.clear_level, 1023));
                r.charger_off = ($urandom_range(0, 9) == 0);
                r.device_standby = ($urandom_range(0, 7) == 0);
                r.device_starting = ($urandom_range(0, 7) == 0);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic test_random();
        int          sent;
        int          len;
        burst_kind_t kind;
        for (int setting = 0; setting < 6; setting++) begin
            write_all(pick_level(), pick_ticks(), pick_level(), pick_ticks());
            sent = 0;
            while (sent < 205) begin
                len = $urandom_range(1, 20);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: kind = BURST_HOT;
                    5, 6, 7:       kind = BURST_COOL;
                    default:       kind = BURST_NOISE;
                endcase
                idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
                repeat (len) send_reading(random_reading(kind));
                sent += len;
            end
            idle_max = IDLE_MAX;
            wait_drained();
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        test_reset_values();
        test_directed();
        test_register_extremes();
        test_timer_top();
        test_random();
        wait_drained();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
